// ----- sv/voc_pkg.sv -----
// Package: shared constants and the signature table of the voice file parser.
`timescale 1ns / 1ps

package voc_pkg;

  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_FINISH = 2'd2;
  localparam logic [1:0] KIND_BAD    = 2'd3;

  localparam int SIG_LEN   = 19;
  localparam int FIRST_BLK = 26;

  localparam logic [19:0] RATE_NUM  = 20'd1000000;
  localparam logic [19:0] RATE_INIT = 20'd22050;
  localparam logic [7:0]  PCM_BIAS  = 8'd128;

  localparam int OUT_DATA_W = 40;

  function automatic logic [7:0] sig_char(input logic [4:0] idx);
    logic [7:0] c;
    case (idx)
      5'd0:    c = 8'h43;
      5'd1:    c = 8'h72;
      5'd2:    c = 8'h65;
      5'd3:    c = 8'h61;
      5'd4:    c = 8'h74;
      5'd5:    c = 8'h69;
      5'd6:    c = 8'h76;
      5'd7:    c = 8'h65;
      5'd8:    c = 8'h20;
      5'd9:    c = 8'h56;
      5'd10:   c = 8'h6F;
      5'd11:   c = 8'h69;
      5'd12:   c = 8'h63;
      5'd13:   c = 8'h65;
      5'd14:   c = 8'h20;
      5'd15:   c = 8'h46;
      5'd16:   c = 8'h69;
      5'd17:   c = 8'h6C;
      5'd18:   c = 8'h65;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ----- sv/voc_stream_parser.sv -----
// Top level: byte-serial voice file parser with a bit-serial rate divider.
`timescale 1ns / 1ps
//
// Input channel s_*: one file byte per item in s_tdata[7:0]; s_tlast high marks end
// of file (the byte is then ignored), which emits the final item and rearms the parser.
// Output channel m_*: exactly one item per input item. m_tuser carries the kind
// (nothing, sample, finished, bad signature); m_tdata carries sample, rate and flags.
// Each item is accepted, then executed: the execute step writes the output register.
// The packing byte of a sound block first passes through the 20-step restoring
// divider, which computes 1000000/(256-r) one quotient bit per cycle.
// The parser takes no new byte before it is through with the last one: s_tready is high
// only while the sequencer is idle.
// One output register parts the channels: the next item is accepted while a result
// waits, and its execute step holds until m_tready frees the output register.
// Reset (rst, synchronous): parser returns to the signature check, rate 22050, no
// output pending.

module voc_stream_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] byte_value
  input  logic        s_tlast,   // end_of_stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [15:0] sample, [35:16] sample_rate, [36] compressed,
                                 // [37] has_samples, [39:38] zero
  output logic [1:0]  m_tuser    // [1:0] kind
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;

  localparam logic [3:0] PH_SIG  = 4'd0;
  localparam logic [3:0] PH_HDR  = 4'd1;
  localparam logic [3:0] PH_TYPE = 4'd2;
  localparam logic [3:0] PH_SIZE = 4'd3;
  localparam logic [3:0] PH_RATE = 4'd4;
  localparam logic [3:0] PH_PACK = 4'd5;
  localparam logic [3:0] PH_DATA = 4'd6;
  localparam logic [3:0] PH_DONE = 4'd7;
  localparam logic [3:0] PH_BAD  = 4'd8;

  localparam logic [4:0] SIG_LAST = 5'(voc_pkg::SIG_LEN - 1);
  localparam logic [4:0] HDR_LAST = 5'(voc_pkg::FIRST_BLK - 1);
  localparam logic [4:0] DIV_LAST = 5'd19;

  logic [1:0]  st;
  logic [7:0]  in_byte;
  logic        in_eos;

  logic [3:0]  phase;
  logic [4:0]  header_index;
  logic [7:0]  block_type;
  logic [23:0] block_size;
  logic [23:0] bytes_left;
  logic [7:0]  rate_code;
  logic [19:0] current_rate;
  logic        compressed_seen;
  logic        samples_seen;
  logic        pcm_mode;

  logic [3:0]  phase_next;
  logic [4:0]  header_index_next;
  logic [7:0]  block_type_next;
  logic [23:0] block_size_next;
  logic [23:0] bytes_left_next;
  logic [7:0]  rate_code_next;
  logic [19:0] current_rate_next;
  logic        compressed_seen_next;
  logic        samples_seen_next;
  logic        pcm_mode_next;

  logic [1:0]  kind_next;
  logic [15:0] sample_next;
  logic        comp_next;
  logic        has_next;

  logic [8:0]  div_rem;
  logic [19:0] div_quo;
  logic [4:0]  div_cnt;
  logic [8:0]  divisor;
  logic [9:0]  trial;
  logic [9:0]  diff;
  logic        qbit;

  logic [23:0] size_merged;
  logic [23:0] data_len;
  logic [23:0] left_dec;
  logic        out_free;
  logic        exec_fire;

  assign s_tready  = (st == ST_IDLE);
  assign out_free  = !m_tvalid || m_tready;
  assign exec_fire = (st == ST_EXEC) && out_free;

  assign divisor = 9'd256 - {1'b0, rate_code};
  assign trial   = {div_rem, voc_pkg::RATE_NUM[div_cnt]};
  assign diff    = trial - {1'b0, divisor};
  assign qbit    = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
    end else begin
      case (st)
        ST_IDLE: begin
          if (s_tvalid) begin
            st <= (!s_tlast && phase == PH_PACK) ? ST_DIV : ST_EXEC;
          end
        end
        ST_DIV: begin
          if (div_cnt == 5'd0) begin
            st <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (out_free) begin
            st <= ST_IDLE;
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_eos  <= s_tlast;
      div_rem <= 9'd0;
      div_quo <= 20'd0;
      div_cnt <= DIV_LAST;
    end else if (st == ST_DIV) begin
      div_rem <= qbit ? diff[8:0] : trial[8:0];
      div_quo <= {div_quo[18:0], qbit};
      div_cnt <= div_cnt - 5'd1;
    end
  end

  always_comb begin
    case (header_index[1:0])
      2'd0:    size_merged = block_size | {16'd0, in_byte};
      2'd1:    size_merged = block_size | {8'd0, in_byte, 8'd0};
      default: size_merged = block_size | {in_byte, 16'd0};
    endcase
  end

  assign data_len = (block_size > 24'd2) ? block_size - 24'd2 : 24'd0;
  assign left_dec = (bytes_left != 24'd0) ? bytes_left - 24'd1 : 24'd0;

  always_comb begin
    phase_next           = phase;
    header_index_next    = header_index;
    block_type_next      = block_type;
    block_size_next      = block_size;
    bytes_left_next      = bytes_left;
    rate_code_next       = rate_code;
    current_rate_next    = current_rate;
    compressed_seen_next = compressed_seen;
    samples_seen_next    = samples_seen;
    pcm_mode_next        = pcm_mode;
    kind_next            = voc_pkg::KIND_NONE;
    sample_next          = 16'd0;
    comp_next            = 1'b0;
    has_next             = 1'b0;
    if (in_eos) begin
      if (phase == PH_SIG || phase == PH_BAD) begin
        kind_next = voc_pkg::KIND_BAD;
      end else begin
        kind_next = voc_pkg::KIND_FINISH;
        has_next  = samples_seen;
        comp_next = compressed_seen && !samples_seen;
      end
    end else begin
      case (phase)
        PH_SIG: begin
          if (in_byte == voc_pkg::sig_char(header_index)) begin
            header_index_next = header_index + 5'd1;
            if (header_index == SIG_LAST) begin
              phase_next = PH_HDR;
            end
          end else begin
            phase_next = PH_BAD;
          end
        end
        PH_HDR: begin
          if (header_index >= HDR_LAST) begin
            header_index_next = 5'd0;
            phase_next        = PH_TYPE;
          end else begin
            header_index_next = header_index + 5'd1;
          end
        end
        PH_TYPE: begin
          block_type_next   = in_byte;
          block_size_next   = 24'd0;
          header_index_next = 5'd0;
          phase_next        = PH_SIZE;
        end
        PH_SIZE: begin
          block_size_next   = size_merged;
          header_index_next = header_index + 5'd1;
          if (header_index >= 5'd2) begin
            header_index_next = 5'd0;
            if (size_merged == 24'd0 || block_type == 8'd0) begin
              phase_next = PH_DONE;
            end else if (block_type == 8'd1) begin
              phase_next = PH_RATE;
            end else begin
              if (block_type == 8'd2) begin
                compressed_seen_next = 1'b1;
              end
              bytes_left_next = size_merged;
              pcm_mode_next   = 1'b0;
              phase_next      = PH_DATA;
            end
          end
        end
        PH_RATE: begin
          rate_code_next = in_byte;
          phase_next     = PH_PACK;
        end
        PH_PACK: begin
          current_rate_next = div_quo;
          if (in_byte != 8'd0) begin
            compressed_seen_next = 1'b1;
          end
          bytes_left_next = data_len;
          pcm_mode_next   = (in_byte == 8'd0);
          phase_next      = (data_len == 24'd0) ? PH_TYPE : PH_DATA;
        end
        PH_DATA: begin
          if (pcm_mode) begin
            kind_next         = voc_pkg::KIND_SAMPLE;
            sample_next       = {in_byte ^ voc_pkg::PCM_BIAS, 8'd0};
            samples_seen_next = 1'b1;
          end
          bytes_left_next = left_dec;
          if (left_dec == 24'd0) begin
            phase_next = PH_TYPE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (exec_fire && in_eos)) begin
      phase           <= PH_SIG;
      header_index    <= 5'd0;
      block_type      <= 8'd0;
      block_size      <= 24'd0;
      bytes_left      <= 24'd0;
      rate_code       <= 8'd0;
      current_rate    <= voc_pkg::RATE_INIT;
      compressed_seen <= 1'b0;
      samples_seen    <= 1'b0;
      pcm_mode        <= 1'b0;
    end else if (exec_fire) begin
      phase           <= phase_next;
      header_index    <= header_index_next;
      block_type      <= block_type_next;
      block_size      <= block_size_next;
      bytes_left      <= bytes_left_next;
      rate_code       <= rate_code_next;
      current_rate    <= current_rate_next;
      compressed_seen <= compressed_seen_next;
      samples_seen    <= samples_seen_next;
      pcm_mode        <= pcm_mode_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (exec_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      m_tuser <= kind_next;
      m_tdata <= {2'b00, has_next, comp_next, current_rate_next, sample_next};
    end
  end

endmodule

// ----- sv/voc_check.sv -----
// Checker: port-level properties of the voice file parser, bound to its top level.
`timescale 1ns / 1ps

module voc_check (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic [1:0]  m_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output item changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted on two cycles in a row");

  a_sample_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != voc_pkg::KIND_SAMPLE |-> m_tdata[15:0] == 16'd0)
    else $error("sample nonzero outside a sample item");

  a_flags_finish_only: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != voc_pkg::KIND_FINISH |-> m_tdata[37:36] == 2'b00)
    else $error("flags set outside a finish item");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[36] && m_tdata[37]) && m_tdata[7:0] == 8'd0)
    else $error("compressed and has_samples both set or sample low byte set");

endmodule

bind voc_stream_parser voc_check u_voc_check (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ----- sim/voc_stream_parser_tb.sv -----
// Testbench: self-checking stimulus and scoreboard for the voice file byte parser.
`timescale 1ns / 1ps

module voc_stream_parser_tb;

  localparam int ITEM_GOAL   = 1150;
  localparam int CALM_ITEMS  = 150;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 40;
  localparam int SQUEEZE_AT  = 400;
  localparam int SQUEEZE_LEN = 300;

  localparam logic [7:0] TYPE_END   = 8'd0;
  localparam logic [7:0] TYPE_SOUND = 8'd1;
  localparam logic [7:0] TYPE_PACKED = 8'd2;

  localparam logic [7:0] SIG_BYTES [voc_pkg::SIG_LEN] = '{
    8'h43, 8'h72, 8'h65, 8'h61, 8'h74, 8'h69, 8'h76, 8'h65, 8'h20, 8'h56,
    8'h6F, 8'h69, 8'h63, 8'h65, 8'h20, 8'h46, 8'h69, 8'h6C, 8'h65
  };

  typedef enum logic [3:0] {
    PS_SIG, PS_HDR, PS_TYPE, PS_SIZE, PS_RATE, PS_PACK, PS_DATA, PS_DONE, PS_BAD
  } parse_state_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] sample;
    logic [19:0]        rate;
    logic               compressed;
    logic               has_samples;
  } voc_result_t;

  class voc_scoreboard;
    parse_state_e st;
    logic [4:0]   hdr_idx;
    logic [7:0]   blk_type;
    logic [23:0]  blk_size;
    logic [23:0]  data_left;
    logic [7:0]   rate_code;
    logic [19:0]  rate;
    bit           comp_seen;
    bit           smp_seen;
    bit           pcm;
    voc_result_t  expected_out[$];
    int           errors;

    function new();
      errors = 0;
      rearm();
    endfunction

    function void rearm();
      st        = PS_SIG;
      hdr_idx   = '0;
      blk_type  = '0;
      blk_size  = '0;
      data_left = '0;
      rate_code = '0;
      rate      = voc_pkg::RATE_INIT;
      comp_seen = 0;
      smp_seen  = 0;
      pcm       = 0;
    endfunction

    function void open_data(input logic [23:0] len, input bit emit);
      data_left = len;
      pcm       = emit;
      st        = (len == 0) ? PS_TYPE : PS_DATA;
    endfunction

    function void parse_byte(input logic [7:0] b, input logic eos);
      voc_result_t r;
      r = '0;
      if (eos) begin
        if (st == PS_SIG || st == PS_BAD) begin
          r.kind = voc_pkg::KIND_BAD;
        end else begin
          r.kind        = voc_pkg::KIND_FINISH;
          r.has_samples = smp_seen;
          r.compressed  = comp_seen && !smp_seen;
        end
        r.rate = rate;
        expected_out.push_back(r);
        rearm();
        return;
      end
      r.kind = voc_pkg::KIND_NONE;
      case (st)
        PS_SIG: begin
          if (hdr_idx < voc_pkg::SIG_LEN && b == SIG_BYTES[hdr_idx]) begin
            hdr_idx++;
            if (hdr_idx == voc_pkg::SIG_LEN) st = PS_HDR;
          end else begin
            st = PS_BAD;
          end
        end
        PS_HDR: begin
          hdr_idx++;
          if (hdr_idx >= voc_pkg::FIRST_BLK) begin
            hdr_idx = '0;
            st      = PS_TYPE;
          end
        end
        PS_TYPE: begin
          blk_type = b;
          blk_size = '0;
          hdr_idx  = '0;
          st       = PS_SIZE;
        end
        PS_SIZE: begin
          blk_size = blk_size | (24'(b) << (8 * hdr_idx[1:0]));
          hdr_idx++;
          if (hdr_idx >= 3) begin
            hdr_idx = '0;
            if (blk_size == 0 || blk_type == TYPE_END) begin
              st = PS_DONE;
            end else if (blk_type == TYPE_SOUND) begin
              st = PS_RATE;
            end else begin
              if (blk_type == TYPE_PACKED) comp_seen = 1;
              open_data(blk_size, 0);
            end
          end
        end
        PS_RATE: begin
          rate_code = b;
          st        = PS_PACK;
        end
        PS_PACK: begin
          rate = 20'(int'(voc_pkg::RATE_NUM) / (256 - int'(rate_code)));
          if (b != 0) comp_seen = 1;
          open_data((blk_size > 2) ? blk_size - 24'd2 : 24'd0, b == 0);
        end
        PS_DATA: begin
          if (pcm) begin
            r.kind   = voc_pkg::KIND_SAMPLE;
            r.sample = {b ^ voc_pkg::PCM_BIAS, 8'h00};
            smp_seen = 1;
          end
          if (data_left > 0) data_left--;
          if (data_left == 0) st = PS_TYPE;
        end
        default: begin
        end
      endcase
      r.rate = rate;
      expected_out.push_back(r);
    endfunction

    function void compare_output(input logic [39:0] data, input logic [1:0] user);
      voc_result_t e;
      if (expected_out.size() == 0) begin
        $display("%0t: unexpected output item, kind %0d data %h", $time, user, data);
        errors++;
        return;
      end
      e = expected_out.pop_front();
      if (user !== e.kind) begin
        $display("%0t: kind expected %0d actual %0d", $time, e.kind, user);
        errors++;
      end
      if (data[15:0] !== e.sample) begin
        $display("%0t: sample expected %h actual %h", $time, e.sample, data[15:0]);
        errors++;
      end
      if (data[35:16] !== e.rate) begin
        $display("%0t: sample_rate expected %0d actual %0d", $time, e.rate, data[35:16]);
        errors++;
      end
      if (data[36] !== e.compressed) begin
        $display("%0t: compressed expected %b actual %b", $time, e.compressed, data[36]);
        errors++;
      end
      if (data[37] !== e.has_samples) begin
        $display("%0t: has_samples expected %b actual %b", $time, e.has_samples, data[37]);
        errors++;
      end
      if (data[39:38] !== 2'b00) begin
        $display("%0t: pad bits expected 00 actual %b", $time, data[39:38]);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;

  voc_scoreboard sb = new();
  logic [7:0]    file_bytes[$];
  int            sent_items = 0;
  int            cycles = 0;
  bit            calm = 0;

  voc_stream_parser i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.compare_output(m_tdata, m_tuser);
  end

  initial begin
    int  stall;
    bit  squeezed;
    squeezed = 0;
    m_tready <= 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!squeezed && sent_items >= SQUEEZE_AT) begin
        squeezed = 1;
        m_tready <= 1'b0;
        repeat (SQUEEZE_LEN) @(negedge clk);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 17);
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  task automatic send_item(input logic [7:0] b, input logic eos);
    if (!calm && $urandom_range(0, 9) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eos;
    do @(posedge clk); while (!s_tready);
    sb.parse_byte(b, eos);
    sent_items++;
    calm = (sent_items >= ITEM_GOAL - CALM_ITEMS);
    @(negedge clk);
  endtask

  task automatic play_file();
    foreach (file_bytes[i]) send_item(file_bytes[i], 1'b0);
    send_item(8'($urandom), 1'b1);
    file_bytes.delete();
  endtask

  function automatic void add_preamble();
    foreach (SIG_BYTES[i]) file_bytes.push_back(SIG_BYTES[i]);
    repeat (voc_pkg::FIRST_BLK - voc_pkg::SIG_LEN) file_bytes.push_back(8'($urandom));
  endfunction

  function automatic void add_block_head(input logic [7:0] typ, input logic [23:0] size);
    file_bytes.push_back(typ);
    file_bytes.push_back(size[7:0]);
    file_bytes.push_back(size[15:8]);
    file_bytes.push_back(size[23:16]);
  endfunction

  task automatic send_random_file();
    int          mode;
    int          nblk;
    int          pick;
    int          len;
    int          cut;
    logic [7:0]  typ;
    logic [7:0]  packing;
    logic [23:0] size;
    bit          closed;
    mode   = $urandom_range(0, 15);
    closed = 0;
    add_preamble();
    if (mode == 0) begin
      cut = $urandom_range(0, voc_pkg::SIG_LEN - 1);
      file_bytes[cut] = file_bytes[cut] ^ 8'($urandom_range(1, 255));
      file_bytes = file_bytes[0 : cut + $urandom_range(0, 6)];
    end else begin
      nblk = $urandom_range(1, 6);
      for (int k = 0; k < nblk && !closed; k++) begin
        pick    = $urandom_range(0, 15);
        size    = 24'($urandom_range(0, 9));
        packing = 8'd0;
        if (pick < 9) begin
          typ = TYPE_SOUND;
        end else if (pick < 11) begin
          typ     = TYPE_SOUND;
          packing = 8'($urandom_range(1, 255));
        end else if (pick < 13) begin
          typ = TYPE_PACKED;
        end else if (pick < 15) begin
          typ = 8'($urandom_range(3, 255));
        end else begin
          typ = $urandom_range(0, 1) ? TYPE_END : 8'($urandom_range(1, 255));
          if (typ != TYPE_END) size = '0;
          else size = 24'($urandom);
        end
        if ($urandom_range(0, 19) == 0 && typ != TYPE_END) begin
          size   = 24'($urandom_range(16, 24'hFFFFFF));
          closed = 1;
        end
        add_block_head(typ, size);
        if (typ == TYPE_END || size == 0) begin
          repeat ($urandom_range(0, 3)) file_bytes.push_back(8'($urandom));
          closed = 1;
        end else begin
          len = size;
          if (typ == TYPE_SOUND) begin
            file_bytes.push_back(8'($urandom));
            file_bytes.push_back(packing);
            len = (size > 2) ? size - 2 : 0;
          end
          if (closed) len = $urandom_range(0, 6);
          repeat (len) file_bytes.push_back(8'($urandom));
        end
      end
      if (mode == 1) file_bytes = file_bytes[0 : $urandom_range(0, file_bytes.size() - 1)];
    end
    play_file();
  endtask

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= 8'h00;
    s_tlast  <= 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // end of file before any byte, then a broken signature with ignored bytes
    send_item(8'hFF, 1'b1);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b1);

    // sound blocks at both rate extremes, short and packed blocks, skipped kinds, stop
    add_preamble();
    add_block_head(TYPE_SOUND, 24'd5);
    file_bytes.push_back(8'h00);
    file_bytes.push_back(8'h00);
    file_bytes.push_back(8'h00);
    file_bytes.push_back(8'hFF);
    file_bytes.push_back(8'h80);
    add_block_head(TYPE_SOUND, 24'd1);
    file_bytes.push_back(8'hFF);
    file_bytes.push_back(8'h00);
    add_block_head(TYPE_SOUND, 24'd3);
    file_bytes.push_back(8'h9C);
    file_bytes.push_back(8'h03);
    file_bytes.push_back(8'h5A);
    add_block_head(TYPE_PACKED, 24'd2);
    file_bytes.push_back(8'hA5);
    file_bytes.push_back(8'h5A);
    add_block_head(8'h07, 24'd1);
    file_bytes.push_back(8'hFF);
    add_block_head(TYPE_END, 24'd1);
    file_bytes.push_back(8'hAA);
    play_file();

    // only a packed block, cut off inside its data
    add_preamble();
    add_block_head(TYPE_PACKED, 24'hFFFFFF);
    file_bytes.push_back(8'h11);
    play_file();

    while (sent_items < ITEM_GOAL) send_random_file();
    s_tvalid <= 1'b0;

    while (sb.expected_out.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
